/* hdl/i2a_pkg.sv */
// Shared types, constants and the power-of-ten table for the integer to
// decimal ASCII converter. No dependencies.
package i2a_pkg;

  localparam int MAG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int FIELD_LEN  = 11;
  localparam int DIG_W      = 4;
  localparam int IDX_W      = 4;
  localparam int THR_W      = 34;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(NUM_DIGITS - 1);
  localparam logic [IDX_W-1:0] LAST_POS   = IDX_W'(FIELD_LEN - 1);

  typedef enum logic {
    MODE_LEFT  = 1'b0,
    MODE_RIGHT = 1'b1
  } mode_t;

  // Classified input item: sign, unsigned magnitude and justification.
  typedef struct packed {
    logic             neg;
    mode_t            mode;
    logic [MAG_W-1:0] mag;
  } item_t;

  // Fully split item: ten decimal digits, most significant first.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIG_W-1:0] digits;
    logic [IDX_W-1:0]                 first;
    logic                             neg;
    mode_t                            mode;
  } rec_t;

  // Weight of digit position idx (position 0 is the billions digit).
  function automatic logic [THR_W-1:0] pow10(input logic [IDX_W-1:0] idx);
    logic [THR_W-1:0] p;
    case (idx)
      4'd0:    p = THR_W'(1000000000);
      4'd1:    p = THR_W'(100000000);
      4'd2:    p = THR_W'(10000000);
      4'd3:    p = THR_W'(1000000);
      4'd4:    p = THR_W'(100000);
      4'd5:    p = THR_W'(10000);
      4'd6:    p = THR_W'(1000);
      4'd7:    p = THR_W'(100);
      4'd8:    p = THR_W'(10);
      4'd9:    p = THR_W'(1);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* hdl/i2a_front.sv */
// Input stage: registers a beat and classifies it into sign and unsigned
// magnitude. Depends on i2a_pkg.
module i2a_front
  import i2a_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_mode,
  output logic               item_valid,
  input  logic               item_ready,
  output item_t              item
);

  logic             valid_r, valid_nxt;
  item_t            item_r, item_nxt;
  logic [MAG_W-1:0] raw;
  logic             take;

  assign raw      = MAG_W'(in_value);
  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt     = 1'b1;
      item_nxt.neg  = raw[MAG_W-1];
      item_nxt.mode = mode_t'(in_mode);
      // Unsigned negate, so the most negative value yields 2^31.
      item_nxt.mag  = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hdl/i2a_queue.sv */
// Two-entry queue of classified items between the input stage and the
// digit extractor. Depends on i2a_pkg.
module i2a_queue
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* hdl/i2a_digits.sv */
// Digit extractor: splits a magnitude into ten decimal digits, one digit
// per cycle from the most significant, and finds the first nonzero one.
// Depends on i2a_pkg.
module i2a_digits
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  rec_valid,
  input  logic  rec_ready,
  output rec_t  rec
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  rec_t             rec_r, rec_nxt;

  logic [THR_W-1:0] pw;
  logic [THR_W-1:0] thr [NUM_DIGITS];
  logic [DIG_W-1:0] dig;
  logic             take, pop;

  assign take       = done_r && rec_ready;
  assign item_ready = !busy_r && (!done_r || rec_ready);
  assign pop        = item_valid && item_ready;

  // Compare the remainder against every multiple of the current weight;
  // the largest multiple that fits gives the digit.
  always_comb begin
    pw  = pow10(idx_r);
    dig = '0;
    for (int m = 0; m < NUM_DIGITS; m++) begin
      thr[m] = pw * THR_W'(m);
    end
    for (int m = 1; m < NUM_DIGITS; m++) begin
      if (THR_W'(mag_r) >= thr[m]) begin
        dig = DIG_W'(m);
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    mag_nxt   = mag_r;
    rec_nxt   = rec_r;
    if (take) begin
      done_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt      = 1'b1;
      found_nxt     = 1'b0;
      idx_nxt       = '0;
      mag_nxt       = item.mag;
      rec_nxt.neg   = item.neg;
      rec_nxt.mode  = item.mode;
      rec_nxt.first = LAST_DIGIT;
    end else if (busy_r) begin
      rec_nxt.digits[idx_r] = dig;
      mag_nxt               = mag_r - thr[dig][MAG_W-1:0];
      if (!found_r && dig != '0) begin
        found_nxt     = 1'b1;
        rec_nxt.first = idx_r;
      end
      if (idx_r == LAST_DIGIT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    mag_r   <= mag_nxt;
    rec_r   <= rec_nxt;
  end

  assign rec_valid = done_r;
  assign rec       = rec_r;

endmodule

/* hdl/i2a_emit.sv */
// Character emitter: walks a digit record and drives one ASCII character
// per beat through a registered output stage. Depends on i2a_pkg.
module i2a_emit
  import i2a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  rec_t              rec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  logic              busy_r, busy_nxt;
  logic              sign_pend_r, sign_pend_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  rec_t              rec_r, rec_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              last_r, last_nxt;

  logic              load, adv, take;
  logic [IDX_W-1:0]  sel;
  logic [DIG_W-1:0]  dsel;
  logic [CHAR_W-1:0] ch_c;
  logic              last_c;

  assign load = !ov_r || out_ready;
  assign adv  = busy_r && load;

  // Left mode: cnt is the digit index; right mode: cnt is the field position,
  // and digit i sits at position i + 1.
  always_comb begin
    sel  = (rec_r.mode == MODE_RIGHT) ? (cnt_r - 1'b1) : cnt_r;
    dsel = (sel < IDX_W'(NUM_DIGITS)) ? rec_r.digits[sel] : '0;
    if (rec_r.mode == MODE_LEFT) begin
      ch_c   = sign_pend_r ? CH_MINUS : (CH_ZERO + CHAR_W'(dsel));
      last_c = !sign_pend_r && (cnt_r == LAST_DIGIT);
    end else begin
      last_c = (cnt_r == LAST_POS);
      if (cnt_r != '0 && sel >= rec_r.first) begin
        ch_c = CH_ZERO + CHAR_W'(dsel);
      end else if (rec_r.neg && cnt_r == rec_r.first) begin
        ch_c = CH_MINUS;
      end else begin
        ch_c = CH_SPACE;
      end
    end
  end

  assign take      = rec_valid && (!busy_r || (adv && last_c));
  assign rec_ready = !busy_r || (adv && last_c);

  always_comb begin
    busy_nxt      = busy_r;
    sign_pend_nxt = sign_pend_r;
    cnt_nxt       = cnt_r;
    rec_nxt       = rec_r;
    ov_nxt        = ov_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    if (adv) begin
      ov_nxt   = 1'b1;
      ch_nxt   = ch_c;
      last_nxt = last_c;
      if (last_c) begin
        busy_nxt = 1'b0;
      end else if (rec_r.mode == MODE_LEFT && sign_pend_r) begin
        sign_pend_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (load) begin
      ov_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt      = 1'b1;
      rec_nxt       = rec;
      sign_pend_nxt = rec.neg;
      cnt_nxt       = (rec.mode == MODE_LEFT) ? rec.first : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    sign_pend_r <= sign_pend_nxt;
    cnt_r       <= cnt_nxt;
    rec_r       <= rec_nxt;
    ch_r        <= ch_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid     = ov_r;
  assign out_character = ch_r;
  assign out_last      = last_r;

endmodule

/* hdl/int32_to_decimal_ascii_core.sv */
// Signed 32-bit integer to decimal ASCII converter, top level.
// Throughput is set by the one-digit-per-cycle extractor, which takes no new item
// until it has stepped through all ten digits, and by the 11 characters of a
// right-justified item.
// Reset: synchronous active-low rst_n empties every stage; data holds no reset.
module int32_to_decimal_ascii_core
  import i2a_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_character,
  output logic               out_last
);

  // The front stage takes a beat, forms its sign and unsigned magnitude, and
  // hands it to a two-entry queue. The back end pulls from the queue: the
  // digit extractor produces ten digits and the first nonzero position, then
  // the emitter walks that record while the extractor starts on the next item.

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;
  logic  r_valid, r_ready;
  rec_t  r_rec;

  i2a_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_mode    (in_mode),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // The queue lets the front keep accepting while the back end is busy.
  i2a_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  i2a_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .rec_valid  (r_valid),
    .rec_ready  (r_ready),
    .rec        (r_rec)
  );

  // The emitter owns the output register, so a stalled result beat never
  // blocks digit extraction of the following item.
  i2a_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (r_valid),
    .rec_ready     (r_ready),
    .rec           (r_rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
